// ===== src/sbsc_pkg.sv =====
// Shared types and constants for the sieve byte square check block.
// No dependencies; imported by the controller, the datapath and the top level.
package sbsc_pkg;

	localparam int unsigned WORD_BITS  = 32;
	localparam int unsigned WIDE_BITS  = 64;
	localparam int unsigned COUNT_BITS = 33;
	localparam int unsigned MASK_BITS  = 8;
	localparam int unsigned FIELD_IDX_BITS = 29;
	localparam int unsigned S_DATA_BITS = 40;
	localparam int unsigned M_DATA_BITS = 104;
	localparam int unsigned CFG_IDX_BITS = 2;
	localparam int unsigned ROOT_STEPS = 32;
	localparam int unsigned STEP_BITS = 5;

	// Configuration register indices.
	localparam logic [CFG_IDX_BITS-1:0] REG_FIRST_ROOT  = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_SECOND_ROOT = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_THIRD_ROOT  = 2'd2;

	typedef enum logic [1:0] {
		MUL_B,
		MUL_C,
		MUL_D
	} mul_sel_t;

	typedef struct packed {
		logic     load_item;
		mul_sel_t mul_sel;
		logic     acc_load;
		logic     acc_add;
		logic     cand_load;
		logic     sqrt_init;
		logic     sqrt_step;
		logic     out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic bits_left;
		logic more_after;
		logic out_busy;
	} dp_status_t;

endpackage

// ===== src/sieve_byte_square_check_core.sv =====
// Sieve byte square check: one result word per set bit of each sieve byte.
// An item first forms b*b + c*c; each set bit then adds one squaring, one
// subtract, 32 root steps at two bits each and one load, and the load waits
// while the previous output word has not been taken.
// A result appears on the output in the cycle after its load. Reset is
// asynchronous, active low, and clears the roots, the running count and control.
module sieve_byte_square_check_core #(
	parameter int unsigned INDEX_BITS = 29
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// Fields from bit 0 up: byte_index (29), mask_byte (8), zero padding (3).
	input  logic [sbsc_pkg::S_DATA_BITS-1:0]      s_tdata,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// Fields from bit 0 up: cand_d (32), root_g (32), is_square (1),
	// ones_so_far (33), zero padding (6).
	output logic [sbsc_pkg::M_DATA_BITS-1:0]      m_tdata,
	// last_of_run: set on the word for the byte's highest set bit.
	output logic                                  m_tlast,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [sbsc_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [sbsc_pkg::WORD_BITS-1:0]        cfg_data
);
	import sbsc_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;
	logic       in_fire;

	// Register writes are always taken; index three is accepted and dropped.
	assign cfg_ready = 1'b1;
	assign in_fire   = s_tvalid & s_tready;

	// The controller walks the set bits from bit 0 upwards. Per item it first
	// forms b*b + c*c on the shared squarer, then for each candidate d squares
	// d, subtracts, and runs the restoring square root. The final remainder
	// tells whether the root is exact.
	sbsc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.status   (status),
		.cmd      (cmd),
		.in_ready (s_tready)
	);

	// The output register lets the next candidate be worked on while a
	// finished word waits to be taken downstream.
	sbsc_dp #(
		.INDEX_BITS (INDEX_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.s_tdata   (s_tdata),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule

// ===== src/sbsc_dp.sv =====
// Datapath of the sieve byte square check: root registers, shared squarer,
// accumulator, two-bits-per-step square root and the output register.
// Depends on sbsc_pkg.
module sbsc_dp #(
	parameter int unsigned INDEX_BITS = 29
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  sbsc_pkg::dp_cmd_t                      cmd,
	output sbsc_pkg::dp_status_t                   status,
	input  logic [sbsc_pkg::S_DATA_BITS-1:0]       s_tdata,
	input  logic                                   cfg_valid,
	input  logic [sbsc_pkg::CFG_IDX_BITS-1:0]      cfg_index,
	input  logic [sbsc_pkg::WORD_BITS-1:0]         cfg_data,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	output logic [sbsc_pkg::M_DATA_BITS-1:0]       m_tdata,
	output logic                                   m_tlast
);
	import sbsc_pkg::*;

	logic [WORD_BITS-1:0]  second_q;
	logic [WORD_BITS-1:0]  third_q;
	logic [INDEX_BITS-1:0] idx_q;
	logic [MASK_BITS-1:0]  mask_q;
	logic [WIDE_BITS-1:0]  prod_q;
	logic [WIDE_BITS-1:0]  acc_q;
	logic [WIDE_BITS-1:0]  x_q;
	logic [WORD_BITS+1:0]  rem_q;
	logic [WORD_BITS-1:0]  root_q;
	logic [WORD_BITS-1:0]  cand_q;
	logic [COUNT_BITS-1:0] count_q;
	logic [WORD_BITS-1:0]  out_cand_q;
	logic [WORD_BITS-1:0]  out_root_q;
	logic                  out_sq_q;
	logic [COUNT_BITS-1:0] out_count_q;
	logic                  out_last_q;
	logic                  out_valid_q;

	logic [WORD_BITS-1:0]  mul_op;
	logic [WIDE_BITS-1:0]  square;
	logic [2:0]            low_bit;
	logic [MASK_BITS-1:0]  mask_rest;
	logic [WORD_BITS-1:0]  cand_next;
	logic [WORD_BITS+3:0]  rem_sh;
	logic [WORD_BITS+3:0]  trial;
	logic                  take;

	// The first root is not stored: its square would enter the sum and be taken
	// out again, which cancels exactly modulo 2^64, so it is left out of the sum.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			second_q <= '0;
			third_q  <= '0;
		end else if (cfg_valid) begin
			if (cfg_index == REG_SECOND_ROOT) begin
				second_q <= cfg_data;
			end else if (cfg_index == REG_THIRD_ROOT) begin
				third_q <= cfg_data;
			end
		end
	end

	always_comb begin
		low_bit = 3'd0;
		for (int k = MASK_BITS - 1; k >= 0; k--) begin
			if (mask_q[k]) begin
				low_bit = 3'(k);
			end
		end
	end

	assign mask_rest = mask_q & (mask_q - 8'd1);
	assign cand_next = WORD_BITS'({idx_q, 3'd7 - low_bit});

	always_comb begin
		unique case (cmd.mul_sel)
			MUL_B:   mul_op = second_q;
			MUL_C:   mul_op = third_q;
			MUL_D:   mul_op = cand_next;
			default: mul_op = second_q;
		endcase
	end

	assign square = {32'd0, mul_op} * {32'd0, mul_op};

	assign rem_sh = {rem_q, x_q[WIDE_BITS-1 -: 2]};
	assign trial  = {2'b00, root_q, 2'b01};

	always_ff @(posedge clk) begin
		prod_q <= square;
		if (cmd.load_item) begin
			idx_q <= s_tdata[INDEX_BITS-1:0];
		end
		if (cmd.acc_load) begin
			acc_q <= prod_q;
		end else if (cmd.acc_add) begin
			acc_q <= acc_q + prod_q;
		end
		if (cmd.cand_load) begin
			cand_q <= cand_next;
		end
		if (cmd.sqrt_init) begin
			x_q    <= acc_q - prod_q;
			rem_q  <= '0;
			root_q <= '0;
		end else if (cmd.sqrt_step) begin
			x_q <= {x_q[WIDE_BITS-3:0], 2'b00};
			if (rem_sh >= trial) begin
				rem_q  <= (WORD_BITS+2)'(rem_sh - trial);
				root_q <= {root_q[WORD_BITS-2:0], 1'b1};
			end else begin
				rem_q  <= (WORD_BITS+2)'(rem_sh);
				root_q <= {root_q[WORD_BITS-2:0], 1'b0};
			end
		end
		if (cmd.out_load) begin
			out_cand_q  <= cand_q;
			out_root_q  <= root_q;
			out_sq_q    <= (rem_q == '0);
			out_count_q <= count_q + 33'd1;
			out_last_q  <= ~|mask_rest;
		end
	end

	assign take = out_valid_q & m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_item) begin
				mask_q <= s_tdata[FIELD_IDX_BITS +: MASK_BITS];
			end else if (cmd.out_load) begin
				mask_q <= mask_rest;
			end
			if (cmd.out_load) begin
				count_q     <= count_q + 33'd1;
				out_valid_q <= 1'b1;
			end else if (take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign status.bits_left  = |mask_q;
	assign status.more_after = |mask_rest;
	assign status.out_busy   = out_valid_q & ~m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {6'd0, out_count_q, out_sq_q, out_root_q, out_cand_q};

endmodule

// ===== src/sbsc_ctrl.sv =====
// Controller of the sieve byte square check: sequences the squarer, the
// accumulator, the root iterations and the output load. Depends on sbsc_pkg.
module sbsc_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_fire,
	input  sbsc_pkg::dp_status_t  status,
	output sbsc_pkg::dp_cmd_t     cmd,
	output logic                  in_ready
);
	import sbsc_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQB,
		ST_SQC,
		ST_SUM,
		ST_SQD,
		ST_SUB,
		ST_ROOT,
		ST_DONE
	} state_t;

	state_t               state_q;
	logic [STEP_BITS-1:0] step_q;
	logic                 ready_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			ready_q <= 1'b1;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_SQB;
						ready_q <= 1'b0;
					end
				end
				ST_SQB: state_q <= ST_SQC;
				ST_SQC: state_q <= ST_SUM;
				ST_SUM: begin
					if (status.bits_left) begin
						state_q <= ST_SQD;
					end else begin
						state_q <= ST_IDLE;
						ready_q <= 1'b1;
					end
				end
				ST_SQD: state_q <= ST_SUB;
				ST_SUB: begin
					state_q <= ST_ROOT;
					step_q  <= '0;
				end
				ST_ROOT: begin
					step_q <= step_q + 5'd1;
					if (step_q == STEP_BITS'(ROOT_STEPS - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!status.out_busy) begin
						if (status.more_after) begin
							state_q <= ST_SQD;
						end else begin
							state_q <= ST_IDLE;
							ready_q <= 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd           = '0;
		cmd.mul_sel   = MUL_B;
		cmd.load_item = (state_q == ST_IDLE) && in_fire;
		unique case (state_q)
			ST_SQC:  begin
				cmd.mul_sel  = MUL_C;
				cmd.acc_load = 1'b1;
			end
			ST_SUM:  cmd.acc_add = 1'b1;
			ST_SQD:  begin
				cmd.mul_sel   = MUL_D;
				cmd.cand_load = 1'b1;
			end
			ST_SUB:  cmd.sqrt_init = 1'b1;
			ST_ROOT: cmd.sqrt_step = 1'b1;
			ST_DONE: cmd.out_load  = ~status.out_busy;
			default: cmd.mul_sel   = MUL_B;
		endcase
	end

	assign in_ready = ready_q;

endmodule

// ===== src/sbsc_chk.sv =====
// Port-level checks for the sieve byte square check core, bound to the top level.
// Depends on sbsc_pkg.
module sbsc_chk (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [sbsc_pkg::M_DATA_BITS-1:0]  m_tdata,
	input logic                              m_tlast
);
	import sbsc_pkg::*;

	// A stalled word keeps its contents.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output word changed while stalled");

	// Every accepted byte keeps the block busy for at least the next cycle.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken again straight after a byte");

	// While a word that is not the last of its byte is shown, the byte is unfinished.
	a_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> !s_tready)
		else $error("input ready while a run is unfinished");

	// The padding bits stay zero.
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[M_DATA_BITS-1 -: 6] == 6'd0)
		else $error("padding bits set in output word");

endmodule

bind sieve_byte_square_check_core sbsc_chk u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

// ===== dv/testbench.sv =====
// Self-checking testbench for sieve_byte_square_check_core: sieve bytes are sent in as
// stream words and every result word is checked against a behavioural copy of the block.
// Depends on sbsc_pkg and the core's RTL only.
`timescale 1ns / 1ps

module testbench;
	import sbsc_pkg::*;

	// The register index above the last real register; writes to it must be dropped.
	localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 2'd3;
	// Wait given to the block after its last result: it is longer than a full byte
	// of eight candidates takes, so this leaves a comfortable margin.
	localparam int SETTLE_CYCLES = 400;
	// Length of the deliberate output stall, long enough to back the block up.
	localparam int STALL_CYCLES = 600;

	// One expected result word, field for field.
	typedef struct packed {
		logic [WORD_BITS-1:0]  cand;
		logic [WORD_BITS-1:0]  root;
		logic                  square;
		logic [COUNT_BITS-1:0] ones;
		logic                  last;
	} sieve_result_t;

	logic                    clk;
	logic                    arst_n;
	logic                    s_tvalid;
	logic                    s_tready;
	logic [S_DATA_BITS-1:0]  s_tdata;
	logic                    m_tvalid;
	logic                    m_tready;
	logic [M_DATA_BITS-1:0]  m_tdata;
	logic                    m_tlast;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [WORD_BITS-1:0]    cfg_data;

	// Our own copy of the three roots and of the running count of set bits.
	logic [WORD_BITS-1:0]  root_a;
	logic [WORD_BITS-1:0]  root_b;
	logic [WORD_BITS-1:0]  root_c;
	logic [COUNT_BITS-1:0] ones_seen;

	// Result words still owed by the block, oldest first.
	sieve_result_t candidate_results[$];

	int error_count;
	int send_idle_pct;
	int recv_idle_pct;
	int hold_req;
	int hold_left;

	sieve_byte_square_check_core #(
		.INDEX_BITS(FIELD_IDX_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// A hard ceiling on the run, far beyond the slowest legal run, so it can
	// only be reached if the block hangs.
	initial begin
		#2_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// Floor square root of a 64-bit value, one result bit at a time from the top:
	// a bit is kept when the trial root squared does not exceed the value.
	function automatic logic [WORD_BITS-1:0] floor_root64(input logic [WIDE_BITS-1:0] value);
		logic [WORD_BITS-1:0] root;
		logic [WIDE_BITS-1:0] trial;
		root = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			trial = {32'd0, root | (32'd1 << i)};
			if (trial * trial <= value)
				root = trial[WORD_BITS-1:0];
		end
		return root;
	endfunction

	// Works out every result word that one accepted sieve byte will produce and
	// queues them. The arithmetic is done at 64 bits so that the remainder wraps
	// exactly as the block's does when d squared outweighs the other terms.
	task automatic work_out_candidates(input logic [FIELD_IDX_BITS-1:0] idx,
			input logic [MASK_BITS-1:0] mask);
		logic [WIDE_BITS-1:0] a64;
		logic [WIDE_BITS-1:0] b64;
		logic [WIDE_BITS-1:0] c64;
		logic [WIDE_BITS-1:0] d64;
		logic [WIDE_BITS-1:0] remainder;
		logic [WIDE_BITS-1:0] g64;
		logic [2:0] low_bits;
		sieve_result_t word;
		int top;
		top = -1;
		a64 = {32'd0, root_a};
		b64 = {32'd0, root_b};
		c64 = {32'd0, root_c};
		for (int k = 0; k < MASK_BITS; k++)
			if (mask[k])
				top = k;
		for (int k = 0; k < MASK_BITS; k++) begin
			if (mask[k]) begin
				low_bits = 3'(7 - k);
				word.cand = {idx, low_bits};
				d64 = {32'd0, word.cand};
				remainder = a64 * a64 + b64 * b64 + c64 * c64 - a64 * a64 - d64 * d64;
				word.root = floor_root64(remainder);
				g64 = {32'd0, word.root};
				word.square = (g64 * g64 == remainder);
				ones_seen = ones_seen + 1'b1;
				word.ones = ones_seen;
				word.last = (k == top);
				candidate_results.push_back(word);
			end
		end
	endtask

	task automatic note_mismatch(input string what, input logic [WIDE_BITS-1:0] got,
			input logic [WIDE_BITS-1:0] want);
		$display("%0t: mismatch in %s: got %h, want %h", $time, what, got, want);
		error_count++;
	endtask

	// Output side. m_tready is driven only here after its initial value. A requested hold-off is picked up
	// and counted down in this process; otherwise the receiver idles at random.
	always @(negedge clk) begin
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// Every word that crosses the output is compared with the oldest one owed.
	always @(posedge clk) begin : check_word
		sieve_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (candidate_results.size() == 0) begin
				note_mismatch("unexpected word", m_tdata[63:0], '0);
			end else begin
				want = candidate_results.pop_front();
				if (m_tdata[31:0] !== want.cand)
					note_mismatch("cand_d", WIDE_BITS'(m_tdata[31:0]),
						WIDE_BITS'(want.cand));
				if (m_tdata[63:32] !== want.root)
					note_mismatch("root_g", WIDE_BITS'(m_tdata[63:32]),
						WIDE_BITS'(want.root));
				if (m_tdata[64] !== want.square)
					note_mismatch("is_square", WIDE_BITS'(m_tdata[64]),
						WIDE_BITS'(want.square));
				if (m_tdata[97:65] !== want.ones)
					note_mismatch("ones_so_far", WIDE_BITS'(m_tdata[97:65]),
						WIDE_BITS'(want.ones));
				if (m_tlast !== want.last)
					note_mismatch("last_of_run", WIDE_BITS'(m_tlast),
						WIDE_BITS'(want.last));
			end
		end
	end

	// Offers one sieve byte and returns at the edge where it is taken. The valid
	// is left high, so back-to-back bytes flow without a gap unless the random
	// idle draw says otherwise; the idle loop lowers it one step at a time.
	task automatic send_sieve_byte(input logic [FIELD_IDX_BITS-1:0] idx,
			input logic [MASK_BITS-1:0] mask);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {3'b000, mask, idx};
		do @(posedge clk); while (!s_tready);
		work_out_candidates(idx, mask);
	endtask

	// Writes one register and mirrors the write in our copy; the unused index
	// must leave everything as it was.
	task automatic write_root_reg(input logic [CFG_IDX_BITS-1:0] index,
			input logic [WORD_BITS-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		case (index)
			REG_FIRST_ROOT:  root_a = value;
			REG_SECOND_ROOT: root_b = value;
			REG_THIRD_ROOT:  root_c = value;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic write_roots(input logic [WORD_BITS-1:0] a, input logic [WORD_BITS-1:0] b,
			input logic [WORD_BITS-1:0] c);
		write_root_reg(REG_FIRST_ROOT, a);
		write_root_reg(REG_SECOND_ROOT, b);
		write_root_reg(REG_THIRD_ROOT, c);
	endtask

	// Drops the input valid and waits for every owed word to arrive.
	task automatic wait_for_results;
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (candidate_results.size() != 0)
			@(posedge clk);
	endtask

	// As above, then gives the block time to finish any zero bytes still inside
	// it, so that a register write that follows lands on an idle block.
	task automatic settle;
		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// With all roots at their reset value of zero, gg is minus d squared, so
	// every candidate except d = 0 exercises the wrapped remainder. Also covers
	// the zero byte, both ends of the index and alternating bit patterns.
	task automatic test_zero_roots;
		send_sieve_byte(29'd0, 8'h80);
		send_sieve_byte(29'd0, 8'h00);
		send_sieve_byte(29'd0, 8'hFF);
		send_sieve_byte(29'h1FFFFFFF, 8'hFF);
		send_sieve_byte(29'h1FFFFFFF, 8'h01);
		send_sieve_byte(29'h0AAAAAAA, 8'h55);
		send_sieve_byte(29'h15555555, 8'hAA);
		send_sieve_byte(29'h15555555, 8'h00);
		settle();
	endtask

	// A write to the unused index must change nothing; then all roots at their
	// maximum, where b squared plus c squared wraps, including d = c, which
	// gives the largest exact root.
	task automatic test_register_extremes;
		write_root_reg(REG_UNUSED, 32'hFFFFFFFF);
		send_sieve_byte(29'd0, 8'h40);
		send_sieve_byte(29'd1, 8'h81);
		settle();
		write_roots(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
		send_sieve_byte(29'h1FFFFFFF, 8'h01);
		send_sieve_byte(29'h1FFFFFFF, 8'hFE);
		send_sieve_byte(29'd0, 8'h01);
		send_sieve_byte(29'h12345678, 8'h3C);
		settle();
	endtask

	// Small roots chosen so that nearby candidates give exact squares (d = c
	// leaves b squared, d = 13 leaves zero), inexact ones and a wrapped remainder.
	task automatic test_square_hits;
		write_roots(32'h12345678, 32'd5, 32'd12);
		send_sieve_byte(29'd1, 8'h0F);
		send_sieve_byte(29'd1, 8'h08);
		send_sieve_byte(29'd1, 8'hF0);
		send_sieve_byte(29'd0, 8'hFF);
		settle();
	endtask

	// Random bytes under random roots, in the three idling modes. Narrow
	// settings keep roots and indices small so that exact squares are common;
	// wide ones use the full range. Many bytes aim d at c, where the remainder
	// is b squared, or just beside it; a few are zero bytes.
	task automatic test_random_traffic;
		logic narrow;
		logic [FIELD_IDX_BITS-1:0] idx;
		logic [MASK_BITS-1:0] mask;
		logic [2:0] low_bits;
		int pick;
		for (int mode = 0; mode < 3; mode++) begin
			case (mode)
				0: begin
					send_idle_pct = 12;
					recv_idle_pct = 54;
				end
				1: begin
					send_idle_pct = 54;
					recv_idle_pct = 12;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (int setting = 0; setting < 2; setting++) begin
				narrow = (setting == 0);
				if (narrow)
					write_roots($urandom_range(0, 4000), $urandom_range(0, 4000),
						$urandom_range(0, 4000));
				else
					write_roots($urandom(), $urandom(), $urandom());
				for (int n = 0; n < 27; n++) begin
					pick = $urandom_range(0, 99);
					mask = 8'($urandom());
					if (pick < 15) begin
						idx = FIELD_IDX_BITS'($urandom());
						mask = 8'h00;
					end else if (pick < 55) begin
						low_bits = root_c[2:0];
						idx = FIELD_IDX_BITS'((root_c >> 3) + $urandom_range(0, 2) - 1);
						mask[7 - low_bits] = 1'b1;
					end else begin
						idx = narrow ? FIELD_IDX_BITS'($urandom_range(0, 600))
							: FIELD_IDX_BITS'($urandom());
					end
					send_sieve_byte(idx, mask);
				end
				settle();
			end
		end
	endtask

	// The receiver holds off for a long stretch while bytes keep coming, every fourth
	// one full, so the block backs up and has to hold its input off too.
	task automatic test_output_stall;
		@(posedge clk);
		hold_req = STALL_CYCLES;
		for (int n = 0; n < 16; n++)
			send_sieve_byte(FIELD_IDX_BITS'($urandom()),
				(n % 4 == 0) ? 8'hFF : 8'($urandom()));
		settle();
	endtask

	// The sender stops until every owed word has come, then carries on under
	// the same roots; the running count must carry across the pause.
	task automatic test_pause_for_drain;
		send_idle_pct = 12;
		recv_idle_pct = 54;
		send_sieve_byte(FIELD_IDX_BITS'($urandom()), 8'hC3);
		send_sieve_byte(FIELD_IDX_BITS'($urandom()), 8'h3C);
		wait_for_results();
		send_sieve_byte(FIELD_IDX_BITS'($urandom()), 8'h81);
		send_sieve_byte(FIELD_IDX_BITS'($urandom()), 8'h7E);
		settle();
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_FIRST_ROOT;
		cfg_data = '0;
		root_a = '0;
		root_b = '0;
		root_c = '0;
		ones_seen = '0;
		error_count = 0;
		hold_req = 0;
		hold_left = 0;
		send_idle_pct = 12;
		recv_idle_pct = 54;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_zero_roots();
		test_register_extremes();
		test_square_hits();
		test_random_traffic();
		test_output_stall();
		test_pause_for_drain();

		// settle() at the end of the last test has already waited for the final
		// word and a full item's worth of cycles beyond it.
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
